@@ hw/rtl/rmq_pkg.sv @@
package rmq_pkg;

   localparam int FRAC_BITS = 14;
   localparam int ONE       = 1 << FRAC_BITS;

   // radicand, root and numerator magnitude widths
   localparam int RAD_W    = 17;
   localparam int S_W      = 17;
   localparam int SQ_STEPS = S_W;
   localparam int RADX_W   = 2 * SQ_STEPS;
   localparam int REM_W    = S_W + 2;
   localparam int MAG_W    = 17;
   localparam int DIV_W    = MAG_W + FRAC_BITS;
   localparam int Q_W      = 16;
   localparam int T_W      = 32;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      BR_TRACE = 2'd0,
      BR_COL0  = 2'd1,
      BR_COL1  = 2'd2,
      BR_COL2  = 2'd3
   } br_type;

   // one classified transform; the three divided numerators in x,y,z,w order
   typedef struct packed {
      br_type                       br;
      logic [RAD_W-1:0]             rad;
      logic [2:0]                   neg;
      logic [2:0][MAG_W-1:0]        mag;
      logic [2:0][T_W-1:0]          trans;
   } item_type;

   // clamp a magnitude to ONE and apply the sign
   function automatic logic signed [Q_W-1:0] sat_mag(input logic [DIV_W-1:0] m,
                                                    input logic neg);
      logic [Q_W-1:0] c;
      if (m > DIV_W'(ONE)) begin
         c = Q_W'(ONE);
      end else begin
         c = m[Q_W-1:0];
      end
      return neg ? -$signed(c) : $signed(c);
   endfunction

endpackage

@@ hw/rtl/rotation_matrix_to_quaternion.sv @@
// Channel  Dir  Signals                          Carries
// req      in   req_tvalid/tready/tdata[239:0]   rotation entries and translation
// rsp      out  rsp_tvalid/tready/tdata[159:0]   quaternion, translation, formula in tuser
// csr      in   csr_wen/csr_wdata[15:0]          trace threshold
//
// One word per cycle while the receiver takes results; the queue, 17-stage square root,
// entry stage, 31-stage divider and output register lie between acceptance and rsp_tvalid.
// A 4-word queue sits between the classifier and the arithmetic pipeline.
// The pipeline holds as one while a result waits; the queue keeps taking words until full.
// Reset is synchronous: pipeline, queue and threshold clear.
module rotation_matrix_to_quaternion (
   input  logic          clock,
   input  logic          reset,
   // r00,r01,r02,r10,r11,r12,r20,r21,r22 (16b each), tx_in,ty_in,tz_in (32b each)
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [239:0]  req_tdata,
   // qx,qy,qz,qw (16b each), tx_out,ty_out,tz_out (32b each)
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [159:0]  rsp_tdata,
   // branch_used
   output logic [1:0]    rsp_tuser,
   input  logic          csr_wen,
   input  logic [15:0]   csr_wdata
);
   import rmq_pkg::*;

   item_type       f_item, q_head, s_item;
   logic           q_full, q_empty, push, pop, en, s_valid;
   logic [S_W-1:0] s_root;

   // stall the back end only while a result waits
   assign en         = !rsp_tvalid || rsp_tready;
   assign push       = req_tvalid && !q_full;
   assign pop        = en && !q_empty;
   assign req_tready = !q_full;

   rmq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .word      (req_tdata),
      .item      (f_item)
   );

   rmq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (f_item),
      .pop       (pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   rmq_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (!q_empty),
      .in_item   (q_head),
      .out_valid (s_valid),
      .out_item  (s_item),
      .out_s     (s_root)
   );

   rmq_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .in_item   (s_item),
      .in_s      (s_root),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata),
      .out_br    (rsp_tuser)
   );

endmodule

@@ hw/rtl/rmq_front.sv @@
module rmq_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wen,
   input  logic [15:0]                csr_wdata,
   input  logic [239:0]               word,
   output rmq_pkg::item_type          item
);
   import rmq_pkg::*;

   logic [15:0] thr_ff;
   logic signed [15:0] r [9];
   logic signed [18:0] t, d0, d1, d2, rsel;
   logic signed [16:0] n_a, n_b, n_c, n_d, n_e, n_f;
   logic signed [16:0] n [3];
   br_type br;

   // hold the trace threshold
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_wen) begin
         thr_ff <= csr_wdata;
      end
   end

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         r[i] = $signed(word[16*i +: 16]);
      end
   end

   // radicands of the four formulas
   assign t  = 19'(ONE) + 19'(r[0]) + 19'(r[4]) + 19'(r[8]);
   assign d0 = 19'(ONE) + 19'(r[0]) - 19'(r[4]) - 19'(r[8]);
   assign d1 = 19'(ONE) + 19'(r[4]) - 19'(r[0]) - 19'(r[8]);
   assign d2 = 19'(ONE) + 19'(r[8]) - 19'(r[0]) - 19'(r[4]);

   // numerator terms
   assign n_a = 17'(r[7]) - 17'(r[5]);
   assign n_b = 17'(r[2]) - 17'(r[6]);
   assign n_c = 17'(r[3]) - 17'(r[1]);
   assign n_d = 17'(r[1]) + 17'(r[3]);
   assign n_e = 17'(r[2]) + 17'(r[6]);
   assign n_f = 17'(r[5]) + 17'(r[7]);

   // pick the formula
   always_comb begin
      if (t > $signed({3'b000, thr_ff})) begin
         br = BR_TRACE;
      end else if (r[0] > r[4] && r[0] > r[8]) begin
         br = BR_COL0;
      end else if (r[4] > r[8]) begin
         br = BR_COL1;
      end else begin
         br = BR_COL2;
      end
   end

   always_comb begin
      case (br)
         BR_TRACE: begin rsel = t;  n[0] = n_a; n[1] = n_b; n[2] = n_c; end
         BR_COL0:  begin rsel = d0; n[0] = n_d; n[1] = n_e; n[2] = n_a; end
         BR_COL1:  begin rsel = d1; n[0] = n_d; n[1] = n_f; n[2] = n_b; end
         BR_COL2:  begin rsel = d2; n[0] = n_e; n[1] = n_f; n[2] = n_c; end
         default:  begin rsel = t;  n[0] = n_a; n[1] = n_b; n[2] = n_c; end
      endcase
   end

   // pack the classified word; a negative radicand counts as zero
   always_comb begin
      item.br  = br;
      item.rad = (rsel > 19'sd0) ? rsel[RAD_W-1:0] : '0;
      for (int j = 0; j < 3; j++) begin
         item.neg[j] = n[j][16];
         item.mag[j] = n[j][16] ? MAG_W'(-n[j]) : MAG_W'(n[j]);
         item.trans[j] = word[144 + 32*j +: 32];
      end
   end

endmodule

@@ hw/rtl/rmq_queue.sv @@
module rmq_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rmq_pkg::item_type   push_item,
   input  logic                pop,
   output rmq_pkg::item_type   head,
   output logic                full,
   output logic                empty
);
   import rmq_pkg::*;

   item_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ff, rd_ff;
   logic [QPTR_W:0]      count_ff;

   assign full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ff];

   // store a word
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   // advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W+1)'(QUEUE_DEPTH)) else $error("queue overfilled");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0) else $error("pop from empty queue");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1) else $error("count lost a push");

endmodule

@@ hw/rtl/rmq_sqrt.sv @@
module rmq_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  rmq_pkg::item_type          in_item,
   output logic                       out_valid,
   output rmq_pkg::item_type          out_item,
   output logic [rmq_pkg::S_W-1:0]    out_s
);
   import rmq_pkg::*;

   logic [SQ_STEPS-1:0] valid_ff, valid_in;
   item_type            item_ff [SQ_STEPS];
   item_type            item_in [SQ_STEPS];
   logic [REM_W-1:0]    rem_ff  [SQ_STEPS];
   logic [REM_W-1:0]    rem_in  [SQ_STEPS];
   logic [S_W-1:0]      root_ff [SQ_STEPS];
   logic [S_W-1:0]      root_in [SQ_STEPS];

   // one root bit per stage
   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
      logic             pv;
      item_type         pit;
      logic [REM_W-1:0] prem;
      logic [S_W-1:0]   proot;
      logic [RADX_W-1:0] v;
      logic [REM_W+1:0] acc;
      logic [REM_W+1:0] trial;

      if (k == 0) begin : g_first
         assign pv    = in_valid;
         assign pit   = in_item;
         assign prem  = '0;
         assign proot = '0;
      end else begin : g_rest
         assign pv    = valid_ff[k-1];
         assign pit   = item_ff[k-1];
         assign prem  = rem_ff[k-1];
         assign proot = root_ff[k-1];
      end

      assign v     = {1'b0, pit.rad, (FRAC_BITS+2)'(0)};
      assign acc   = {prem, v[RADX_W-1-2*k -: 2]};
      assign trial = (REM_W+2)'({proot, 2'b01});

      always_comb begin
         valid_in[k] = pv;
         item_in[k]  = pit;
         if (acc >= trial) begin
            rem_in[k]  = REM_W'(acc - trial);
            root_in[k] = {proot[S_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = acc[REM_W-1:0];
            root_in[k] = {proot[S_W-2:0], 1'b0};
         end
      end
   end

   // advance all stages together
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign out_valid = valid_ff[SQ_STEPS-1];
   assign out_item  = item_ff[SQ_STEPS-1];
   assign out_s     = root_ff[SQ_STEPS-1];

endmodule

@@ hw/rtl/rmq_div.sv @@
module rmq_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  rmq_pkg::item_type          in_item,
   input  logic [rmq_pkg::S_W-1:0]    in_s,
   output logic                       out_valid,
   output logic [159:0]               out_data,
   output logic [1:0]                 out_br
);
   import rmq_pkg::*;

   localparam int NST = DIV_W;

   // entry stage: form the rounded dividends
   logic                         pv_ff;
   item_type                     pit_ff;
   logic [S_W-1:0]               ps_ff;
   logic [2:0][DIV_W-1:0]        pdvd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (en) begin
         pv_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pit_ff <= in_item;
         ps_ff  <= in_s;
         for (int j = 0; j < 3; j++) begin
            pdvd_ff[j] <= DIV_W'({in_item.mag[j], FRAC_BITS'(0)}) + DIV_W'(in_s >> 1);
         end
      end
   end

   // restoring division, one quotient bit per stage
   logic [NST-1:0]          valid_ff, valid_in;
   item_type                item_ff [NST];
   item_type                item_in [NST];
   logic [S_W-1:0]          s_ff    [NST];
   logic [S_W-1:0]          s_in    [NST];
   logic [2:0][DIV_W-1:0]   dvd_ff  [NST];
   logic [2:0][DIV_W-1:0]   dvd_in  [NST];
   logic [2:0][S_W-1:0]     rem_ff  [NST];
   logic [2:0][S_W-1:0]     rem_in  [NST];
   logic [2:0][DIV_W-1:0]   quo_ff  [NST];
   logic [2:0][DIV_W-1:0]   quo_in  [NST];

   for (genvar k = 0; k < NST; k++) begin : g_step
      logic                  pv;
      item_type              pit;
      logic [S_W-1:0]        ps;
      logic [2:0][DIV_W-1:0] pdvd;
      logic [2:0][S_W-1:0]   prem;
      logic [2:0][DIV_W-1:0] pquo;

      if (k == 0) begin : g_first
         assign pv   = pv_ff;
         assign pit  = pit_ff;
         assign ps   = ps_ff;
         assign pdvd = pdvd_ff;
         assign prem = '0;
         assign pquo = '0;
      end else begin : g_rest
         assign pv   = valid_ff[k-1];
         assign pit  = item_ff[k-1];
         assign ps   = s_ff[k-1];
         assign pdvd = dvd_ff[k-1];
         assign prem = rem_ff[k-1];
         assign pquo = quo_ff[k-1];
      end

      always_comb begin
         logic [S_W:0] acc;
         valid_in[k] = pv;
         item_in[k]  = pit;
         s_in[k]     = ps;
         dvd_in[k]   = pdvd;
         for (int j = 0; j < 3; j++) begin
            acc = {prem[j], pdvd[j][DIV_W-1-k]};
            if (acc >= {1'b0, ps}) begin
               rem_in[k][j] = S_W'(acc - {1'b0, ps});
               quo_in[k][j] = {pquo[j][DIV_W-2:0], 1'b1};
            end else begin
               rem_in[k][j] = acc[S_W-1:0];
               quo_in[k][j] = {pquo[j][DIV_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
         s_ff    <= s_in;
         dvd_ff  <= dvd_in;
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
      end
   end

   // saturate and place components by formula
   item_type                 lit;
   logic [S_W-1:0]           ls;
   logic [2:0][DIV_W-1:0]    lq;
   logic [S_W:0]             qsum;
   logic signed [Q_W-1:0]    diag, c0, c1, c2;
   logic signed [Q_W-1:0]    qx, qy, qz, qw;

   assign lit  = item_ff[NST-1];
   assign ls   = s_ff[NST-1];
   assign lq   = quo_ff[NST-1];
   assign qsum = (S_W+1)'(ls) + (S_W+1)'(2);

   always_comb begin
      if (ls == '0) begin
         diag = '0;
         c0   = '0;
         c1   = '0;
         c2   = '0;
      end else begin
         diag = sat_mag(DIV_W'(qsum >> 2), 1'b0);
         c0   = sat_mag(lq[0], lit.neg[0]);
         c1   = sat_mag(lq[1], lit.neg[1]);
         c2   = sat_mag(lq[2], lit.neg[2]);
      end
      case (lit.br)
         BR_TRACE: begin qx = c0;   qy = c1;   qz = c2;   qw = diag; end
         BR_COL0:  begin qx = diag; qy = c0;   qz = c1;   qw = c2;   end
         BR_COL1:  begin qx = c0;   qy = diag; qz = c1;   qw = c2;   end
         BR_COL2:  begin qx = c0;   qy = c1;   qz = diag; qw = c2;   end
         default:  begin qx = c0;   qy = c1;   qz = c2;   qw = diag; end
      endcase
   end

   // output register
   logic         ov_ff;
   logic [159:0] od_ff;
   logic [1:0]   ob_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= valid_ff[NST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         od_ff <= {lit.trans[2], lit.trans[1], lit.trans[0], qw, qz, qy, qx};
         ob_ff <= lit.br;
      end
   end

   assign out_valid = ov_ff;
   assign out_data  = od_ff;
   assign out_br    = ob_ff;

endmodule

@@ bench/tb_top.sv @@
module tb_top;
   import rmq_pkg::*;

   localparam int LATENCY   = 51;
   localparam int MAX_CYCLE = 2000000;
   localparam int N_RANDOM  = 1500;
   localparam int FB        = 14;
   localparam longint UNIT  = 64'sd1 << FB;

   typedef struct packed {
      logic signed [15:0] qx, qy, qz, qw;
      logic [31:0]        tx, ty, tz;
      br_type             br;
   } quat_word_type;

   typedef struct {
      logic [239:0]  data;
      logic          fixed;
      quat_word_type want;
   } stim_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [239:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [159:0]  rsp_tdata;
   logic [1:0]    rsp_tuser;
   logic          csr_wen = 1'b0;
   logic [15:0]   csr_wdata = '0;

   rotation_matrix_to_quaternion u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic [15:0]   threshold_q = '0;
   quat_word_type pending_quats[$];
   int            fail_count = 0;
   int            words_in = 0;
   int            words_out = 0;
   int            cycle = 0;
   int            tx_idle_pct = 0;
   int            rx_idle_pct = 0;
   int            br_seen[4] = '{0, 0, 0, 0};
   int            sat_seen = 0;

   // integer square root, bit by bit
   function automatic longint unsigned root_of(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned twice_root(longint r);
      if (r <= 0) return 0;
      return root_of(longint'(r) << (FB + 2));
   endfunction

   // divide by S on magnitudes, round half away from zero
   function automatic longint over_s(longint n, longint unsigned s);
      longint unsigned mag, q;
      if (s == 0) return 0;
      mag = (n < 0) ? longint'(-n) : longint'(n);
      q = ((mag << FB) + (s >> 1)) / s;
      return (n < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic signed [15:0] clamp_q(longint v);
      if (v > UNIT) v = UNIT;
      if (v < -UNIT) v = -UNIT;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic quat_word_type to_quaternion(logic [239:0] d, logic [15:0] thr);
      longint r[9];
      longint t, x, y, z, w;
      longint unsigned s;
      quat_word_type q;
      for (int i = 0; i < 9; i++) r[i] = longint'($signed(d[16*i +: 16]));
      t = UNIT + r[0] + r[4] + r[8];
      if (t > longint'(thr)) begin
         q.br = BR_TRACE;
         s = twice_root(t);
         x = over_s(r[7] - r[5], s);
         y = over_s(r[2] - r[6], s);
         z = over_s(r[3] - r[1], s);
         w = longint'((s + 2) >> 2);
      end else if (r[0] > r[4] && r[0] > r[8]) begin
         q.br = BR_COL0;
         s = twice_root(UNIT + r[0] - r[4] - r[8]);
         x = longint'((s + 2) >> 2);
         y = over_s(r[1] + r[3], s);
         z = over_s(r[2] + r[6], s);
         w = over_s(r[7] - r[5], s);
      end else if (r[4] > r[8]) begin
         q.br = BR_COL1;
         s = twice_root(UNIT + r[4] - r[0] - r[8]);
         x = over_s(r[1] + r[3], s);
         y = longint'((s + 2) >> 2);
         z = over_s(r[5] + r[7], s);
         w = over_s(r[2] - r[6], s);
      end else begin
         q.br = BR_COL2;
         s = twice_root(UNIT + r[8] - r[0] - r[4]);
         x = over_s(r[2] + r[6], s);
         y = over_s(r[5] + r[7], s);
         z = longint'((s + 2) >> 2);
         w = over_s(r[3] - r[1], s);
      end
      q.qx = clamp_q(x);
      q.qy = clamp_q(y);
      q.qz = clamp_q(z);
      q.qw = clamp_q(w);
      q.tx = d[144 +: 32];
      q.ty = d[176 +: 32];
      q.tz = d[208 +: 32];
      return q;
   endfunction

   function automatic logic [239:0] pack_word(longint r[9], logic [31:0] tx, ty, tz);
      logic [239:0] d;
      for (int i = 0; i < 9; i++) d[16*i +: 16] = r[i][15:0];
      d[144 +: 32] = tx;
      d[176 +: 32] = ty;
      d[208 +: 32] = tz;
      return d;
   endfunction

   function automatic longint rand_entry();
      return longint'($urandom_range(32768)) - 16384;
   endfunction

   // near-rotation: signed permutation with small perturbation, else random or all +-one entries
   function automatic logic [239:0] rand_word();
      longint r[9];
      int perm[3];
      int tmp, j, mode;
      perm = '{0, 1, 2};
      mode = $urandom_range(9);
      for (int i = 2; i > 0; i--) begin
         j = $urandom_range(i);
         tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
      end
      for (int i = 0; i < 9; i++) begin
         if (mode < 3) begin
            r[i] = rand_entry();
         end else if (mode == 3) begin
            r[i] = ($urandom_range(1)) ? 16384 : -16384;
         end else begin
            r[i] = longint'($urandom_range(2000)) - 1000;
            if (perm[i/3] == i%3)
               r[i] = (($urandom_range(1)) ? 16384 : -16384) - r[i] / 2;
            if (r[i] > 16384) r[i] = 16384;
            if (r[i] < -16384) r[i] = -16384;
         end
      end
      return pack_word(r, $urandom, $urandom, $urandom);
   endfunction

   // pick a random idle decision per cycle
   function automatic logic idle_now(int pct);
      return ($urandom_range(99) < pct);
   endfunction

   // drain: drop valid, hold off until every expected word has come, then settle
   task automatic drain_pipe();
      req_tvalid <= 1'b0;
      while (pending_quats.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_threshold(logic [15:0] v);
      drain_pipe();
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_wen   <= 1'b0;
      threshold_q = v;
   endtask

   // send one word, idling the sender at random; valid stays up for the next word
   task automatic send_word(logic [239:0] d);
      while (idle_now(tx_idle_pct)) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // record predicted word at acceptance
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         pending_quats.push_back(to_quaternion(req_tdata, threshold_q));
         words_in++;
      end
   end

   // check results against the oldest expectation
   always @(posedge clock) begin
      quat_word_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.qx = rsp_tdata[15:0];
         got.qy = rsp_tdata[31:16];
         got.qz = rsp_tdata[47:32];
         got.qw = rsp_tdata[63:48];
         got.tx = rsp_tdata[95:64];
         got.ty = rsp_tdata[127:96];
         got.tz = rsp_tdata[159:128];
         got.br = br_type'(rsp_tuser);
         words_out++;
         if (pending_quats.size() == 0) begin
            $display("%0t unexpected word: actual %h", $realtime, got);
            fail_count++;
         end else begin
            want = pending_quats.pop_front();
            br_seen[want.br]++;
            if (want.qx == 16384 || want.qx == -16384 || want.qw == 16384) sat_seen++;
            if (got.qx !== want.qx) begin
               $display("%0t qx expected %0d actual %0d", $realtime, want.qx, got.qx);
               fail_count++;
            end
            if (got.qy !== want.qy) begin
               $display("%0t qy expected %0d actual %0d", $realtime, want.qy, got.qy);
               fail_count++;
            end
            if (got.qz !== want.qz) begin
               $display("%0t qz expected %0d actual %0d", $realtime, want.qz, got.qz);
               fail_count++;
            end
            if (got.qw !== want.qw) begin
               $display("%0t qw expected %0d actual %0d", $realtime, want.qw, got.qw);
               fail_count++;
            end
            if (got.tx !== want.tx) begin
               $display("%0t tx expected %h actual %h", $realtime, want.tx, got.tx);
               fail_count++;
            end
            if (got.ty !== want.ty) begin
               $display("%0t ty expected %h actual %h", $realtime, want.ty, got.ty);
               fail_count++;
            end
            if (got.tz !== want.tz) begin
               $display("%0t tz expected %h actual %h", $realtime, want.tz, got.tz);
               fail_count++;
            end
            if (got.br !== want.br) begin
               $display("%0t branch expected %0d actual %0d", $realtime, want.br, got.br);
               fail_count++;
            end
         end
      end
   end

   // drive receiver ready at the falling edge
   always @(negedge clock) begin
      rsp_tready <= !idle_now(rx_idle_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle++;
      if (cycle > MAX_CYCLE) begin
         $display("timeout at cycle %0d, %0d words pending", cycle, pending_quats.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   stim_row_type dir_rows[$];

   task automatic add_row(longint r[9], logic [31:0] tx, ty, tz, logic fixed,
                          quat_word_type want);
      stim_row_type row;
      row.data  = pack_word(r, tx, ty, tz);
      row.fixed = fixed;
      row.want  = want;
      dir_rows.push_back(row);
   endtask

   initial begin
      quat_word_type none, wq, pq;
      longint m[9];
      logic [15:0] thr_set[6];
      none = '0;

      // directed table: identity and half turns read off at a glance
      m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
      wq = '{qx: 0, qy: 0, qz: 0, qw: 16384, tx: 32'h7fffffff, ty: 32'h80000000,
             tz: 32'h0, br: BR_TRACE};
      add_row(m, 32'h7fffffff, 32'h80000000, 32'h0, 1'b1, wq);
      m = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};
      wq = '{qx: 16384, qy: 0, qz: 0, qw: 0, tx: 32'hffffffff, ty: 32'h1,
             tz: 32'h55555555, br: BR_COL0};
      add_row(m, 32'hffffffff, 32'h1, 32'h55555555, 1'b1, wq);
      m = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384};
      wq = '{qx: 0, qy: 16384, qz: 0, qw: 0, tx: 32'haaaaaaaa, ty: 0, tz: 0,
             br: BR_COL1};
      add_row(m, 32'haaaaaaaa, 0, 0, 1'b1, wq);
      m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};
      wq = '{qx: 0, qy: 0, qz: 16384, qw: 0, tx: 0, ty: 0, tz: 32'hffffffff,
             br: BR_COL2};
      add_row(m, 0, 0, 32'hffffffff, 1'b1, wq);
      // predictor-checked rows: all diagonal entries at minus one, saturation,
      // extremes, ties in the diagonal
      m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384};
      add_row(m, 0, 0, 0, 1'b0, none);
      m = '{16384, 16384, -16384, -16384, 16384, 16384, 16384, -16384, 16384};
      add_row(m, 1, 2, 3, 1'b0, none);
      m = '{-16384, 16384, 16384, 16384, -16384, 16384, 16384, 16384, -16384};
      add_row(m, 4, 5, 6, 1'b0, none);
      m = '{0, 16384, 16384, 16384, 0, 16384, 16384, 16384, 0};
      add_row(m, 7, 8, 9, 1'b0, none);
      m = '{-8192, 16384, -16384, 16384, -8192, -16384, -16384, 16384, -8192};
      add_row(m, 32'h12345678, 0, 0, 1'b0, none);
      m = '{-16383, -16384, 16384, 16384, -16384, -16384, -16384, 16384, -16384};
      add_row(m, 0, 32'hdeadbeef, 0, 1'b0, none);
      m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
      add_row(m, 0, 0, 32'hcafef00d, 1'b0, none);
      m = '{11585, -11585, 0, 11585, 11585, 0, 0, 0, 16384};
      add_row(m, 10, 11, 12, 1'b0, none);
      m = '{5000, 5000, 5000, 0, 5000, 0, 0, 0, 5000};
      add_row(m, 13, 14, 15, 1'b0, none);

      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part at reset threshold
      foreach (dir_rows[i]) begin
         send_word(dir_rows[i].data);
         if (dir_rows[i].fixed) begin
            pq = to_quaternion(dir_rows[i].data, threshold_q);
            if (pq !== dir_rows[i].want) begin
               $display("%0t table row %0d expected %h predictor %h", $realtime, i,
                        dir_rows[i].want, pq);
               fail_count++;
            end
         end
      end

      // directed rows again at the highest threshold: diagonal branches mostly
      write_threshold(16'hffff);
      foreach (dir_rows[i]) send_word(dir_rows[i].data);

      // random part across thresholds and idling profiles
      thr_set = '{16'h0000, 16'hffff, 16'h4000, 16'h2000, 16'h8000, 16'h0800};
      for (int ph = 0; ph < 3; ph++) begin
         tx_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 70 : 0;
         rx_idle_pct = (ph == 0) ? 70 : (ph == 1) ? 29 : 0;
         for (int k = 0; k < 6; k++) begin
            if (k == 0 || $urandom_range(1))
               write_threshold(thr_set[(ph * 2 + k) % 6]);
            else
               write_threshold(16'($urandom));
            for (int n = 0; n < N_RANDOM / 18; n++) send_word(rand_word());
         end
      end

      // final drain, then settle
      req_tvalid <= 1'b0;
      while (pending_quats.size() != 0) @(negedge clock);
      repeat (LATENCY + 8) @(negedge clock);

      $display("words in %0d out %0d; branches trace %0d col0 %0d col1 %0d col2 %0d",
               words_in, words_out, br_seen[0], br_seen[1], br_seen[2], br_seen[3]);
      $display("threshold settings incl. 0 and 65535, unit-magnitude results %0d", sat_seen);
      if (fail_count == 0 && pending_quats.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
